@@ rtl/core/tmcc_pkg.sv @@
// shared types, constants and reference color tables for the tile mean color classifier
package tmcc_pkg;

  localparam int unsigned ColorW   = 8;
  localparam int unsigned PixelW   = 24;
  localparam int unsigned ThrW     = 18;
  localparam int unsigned DistW    = 18;
  localparam int unsigned NumDark  = 6;
  localparam int unsigned NumRefs  = 12;
  localparam int unsigned RefIdxW  = 4;
  localparam int unsigned QuotW    = 8;
  localparam int unsigned BitCntW  = 3;

  localparam logic [ThrW-1:0] DarkThrReset  = 18'd1400;
  localparam logic [ThrW-1:0] LightThrReset = 18'd900;

  typedef enum logic [0:0] {
    REG_DARK_THR  = 1'b0,
    REG_LIGHT_THR = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_BLACK  = 3'd1,
    CLS_BLUE   = 3'd2,
    CLS_GOLD   = 3'd3,
    CLS_GREEN  = 3'd4,
    CLS_PURPLE = 3'd5,
    CLS_RED    = 3'd6
  } class_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_CLS,
    BK_DONE
  } back_state_e;

  // dark references first, then light ones, packed as r,g,b
  function automatic logic [PixelW-1:0] ref_color(input logic [RefIdxW-1:0] idx);
    logic [PixelW-1:0] c;
    case (idx)
      4'd0:    c = {8'd89,  8'd87,  8'd85};
      4'd1:    c = {8'd77,  8'd168, 8'd205};
      4'd2:    c = {8'd135, 8'd139, 8'd61};
      4'd3:    c = {8'd86,  8'd166, 8'd48};
      4'd4:    c = {8'd81,  8'd32,  8'd90};
      4'd5:    c = {8'd144, 8'd50,  8'd24};
      4'd6:    c = {8'd134, 8'd132, 8'd130};
      4'd7:    c = {8'd116, 8'd190, 8'd219};
      4'd8:    c = {8'd148, 8'd162, 8'd111};
      4'd9:    c = {8'd124, 8'd183, 8'd98};
      4'd10:   c = {8'd124, 8'd97,  8'd128};
      4'd11:   c = {8'd172, 8'd108, 8'd91};
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic class_e class_from_idx(input logic [RefIdxW-1:0] idx);
    logic [RefIdxW-1:0] k;
    k = (idx < RefIdxW'(NumDark)) ? idx : idx - RefIdxW'(NumDark);
    return class_e'(3'(k + 4'd1));
  endfunction

endpackage

@@ rtl/core/tmcc_front.sv @@
// front end: accepts samples, accumulates channel sums and count, queues finished tiles
module tmcc_front #(
  parameter int unsigned MAX_SAMPLES = 4096,
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW  = $clog2(MAX_SAMPLES * 255 + 1),
  localparam int unsigned TileW = 3 * SumW + CntW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pix_valid_i,
  output logic             pix_ready_o,
  input  logic [23:0]      pixel_i,
  input  logic             last_i,
  input  logic             q_full_i,
  output logic             tile_push_o,
  output logic [TileW-1:0] tile_o
);
  import tmcc_pkg::*;

  logic [SumW-1:0] r_sum_q, r_sum_d, g_sum_q, g_sum_d, b_sum_q, b_sum_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            accept;
  logic [SumW-1:0] r_acc, g_acc, b_acc;
  logic [CntW-1:0] cnt_acc;
  logic            ovf_acc;

  assign pix_ready_o = !q_full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    r_acc   = r_sum_q;
    g_acc   = g_sum_q;
    b_acc   = b_sum_q;
    cnt_acc = cnt_q;
    ovf_acc = ovf_q;
    if (cnt_q < CntW'(MAX_SAMPLES)) begin
      r_acc   = r_sum_q + SumW'(pixel_i[23:16]);
      g_acc   = g_sum_q + SumW'(pixel_i[15:8]);
      b_acc   = b_sum_q + SumW'(pixel_i[7:0]);
      cnt_acc = cnt_q + CntW'(1);
    end else begin
      ovf_acc = 1'b1;
    end
  end

  always_comb begin
    r_sum_d = r_sum_q;
    g_sum_d = g_sum_q;
    b_sum_d = b_sum_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    if (accept) begin
      if (last_i) begin
        r_sum_d = '0;
        g_sum_d = '0;
        b_sum_d = '0;
        cnt_d   = '0;
        ovf_d   = 1'b0;
      end else begin
        r_sum_d = r_acc;
        g_sum_d = g_acc;
        b_sum_d = b_acc;
        cnt_d   = cnt_acc;
        ovf_d   = ovf_acc;
      end
    end
  end

  assign tile_push_o = accept && last_i;
  assign tile_o      = {ovf_acc, cnt_acc, b_acc, g_acc, r_acc};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_sum_q <= '0;
      g_sum_q <= '0;
      b_sum_q <= '0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      r_sum_q <= r_sum_d;
      g_sum_q <= g_sum_d;
      b_sum_q <= b_sum_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ rtl/core/tmcc_fifo.sv @@
// two-entry queue of finished tiles between front and back
module tmcc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import tmcc_pkg::*;

  localparam int unsigned Depth = 2;

  logic [WIDTH-1:0] mem_q [Depth];
  logic             wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(Depth));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full tile queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty tile queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth)) else $error("tile queue count out of range");

  a_cnt_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("tile queue count did not grow on push");

endmodule

@@ rtl/core/tmcc_back.sv @@
// back end: divides sums into channel means, scans reference colors, holds the result beat
module tmcc_back #(
  parameter int unsigned MAX_SAMPLES = 4096,
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1),
  localparam int unsigned SumW  = $clog2(MAX_SAMPLES * 255 + 1),
  localparam int unsigned TileW = 3 * SumW + CntW + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [TileW-1:0]       tile_i,
  input  logic                   q_empty_i,
  output logic                   q_pop_o,
  input  logic [17:0]            dark_thr_i,
  input  logic [17:0]            light_thr_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output tmcc_pkg::class_e       res_class_o,
  output logic                   res_ovf_o
);
  import tmcc_pkg::*;

  localparam int unsigned DivW = CntW + QuotW;

  back_state_e        state_q, state_d;
  logic [DivW-1:0]    rem_q [3];
  logic [DivW-1:0]    rem_d [3];
  logic [QuotW-1:0]   mean_q [3];
  logic [QuotW-1:0]   mean_d [3];
  logic [DivW-1:0]    div_q;
  logic [BitCntW-1:0] bit_q;
  logic [RefIdxW-1:0] idx_q;
  logic               zero_q, ovf_q;
  class_e             cls_q;
  logic               out_valid_q;
  class_e             out_class_q;
  logic               out_ovf_q;

  logic [SumW-1:0]    tile_sum [3];
  logic [CntW-1:0]    tile_cnt;
  logic               tile_ovf;
  logic [PixelW-1:0]  ref_c;
  logic signed [9:0]  diff [3];
  logic signed [19:0] prod [3];
  logic [DistW-1:0]   sq_dist;
  logic [ThrW-1:0]    thr;
  logic               hit;
  logic               ld_out;

  assign tile_sum[0] = tile_i[SumW-1:0];
  assign tile_sum[1] = tile_i[2*SumW-1:SumW];
  assign tile_sum[2] = tile_i[3*SumW-1:2*SumW];
  assign tile_cnt    = tile_i[3*SumW+CntW-1:3*SumW];
  assign tile_ovf    = tile_i[TileW-1];

  // restoring division step, one quotient bit per cycle for all channels
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (rem_q[c] >= div_q) begin
        rem_d[c]  = rem_q[c] - div_q;
        mean_d[c] = {mean_q[c][QuotW-2:0], 1'b1};
      end else begin
        rem_d[c]  = rem_q[c];
        mean_d[c] = {mean_q[c][QuotW-2:0], 1'b0};
      end
    end
  end

  // squared distance of the mean to one reference color
  always_comb begin
    ref_c = ref_color(idx_q);
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({2'b00, ref_c[(2-c)*ColorW +: ColorW]})
              - $signed({2'b00, mean_q[c]});
      prod[c] = diff[c] * diff[c];
    end
    sq_dist = DistW'(prod[0][15:0]) + DistW'(prod[1][15:0]) + DistW'(prod[2][15:0]);
    thr     = (idx_q < RefIdxW'(NumDark)) ? dark_thr_i : light_thr_i;
    hit     = sq_dist < thr;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) state_d = BK_DIV;
      end
      BK_DIV: begin
        if (bit_q == '0) state_d = zero_q ? BK_DONE : BK_CLS;
      end
      BK_CLS: begin
        if (hit || idx_q == RefIdxW'(NumRefs - 1)) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_q || res_ready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = (state_q == BK_IDLE) && !q_empty_i;
    ld_out  = (state_q == BK_DONE) && (!out_valid_q || res_ready_i);
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int c = 0; c < 3; c++) begin
        rem_q[c]  <= DivW'(tile_sum[c]);
        mean_q[c] <= '0;
      end
      div_q  <= DivW'(tile_cnt) << (QuotW - 1);
      bit_q  <= BitCntW'(QuotW - 1);
      idx_q  <= '0;
      zero_q <= (tile_cnt == '0);
      ovf_q  <= tile_ovf;
      cls_q  <= CLS_NONE;
    end else if (state_q == BK_DIV) begin
      rem_q  <= rem_d;
      mean_q <= mean_d;
      div_q  <= div_q >> 1;
      bit_q  <= bit_q - BitCntW'(1);
    end else if (state_q == BK_CLS) begin
      if (hit) begin
        cls_q <= class_from_idx(idx_q);
      end
      idx_q <= idx_q + RefIdxW'(1);
    end
    if (ld_out) begin
      out_class_q <= cls_q;
      out_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_class_o = out_class_q;
  assign res_ovf_o   = out_ovf_q;

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == BK_DIV) else $error("tile popped but division not started");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_ready_i |=> out_valid_q && $stable(out_class_q))
    else $error("result changed while stalled");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_CLS |-> idx_q < RefIdxW'(NumRefs)) else $error("reference scan overran");

endmodule

@@ rtl/core/tile_mean_color_classifier.sv @@
// top level of the tile mean color classifier: register file, front, tile queue, back
//
// Samples enter on the s_axis channel, one 24-bit RGB pixel per beat, tlast marking the
// final sample of a tile. Channel sums and the sample count grow by one beat per cycle
// while s_axis_tready is high; samples beyond MAX_SAMPLES are dropped and flagged. Each
// tile gives one result beat on m_axis: the class code (0 none, 1 black .. 6 red) and
// the overflow flag. Throughput: one sample per cycle while the queue is not full. A
// finished tile enters a two-deep queue; the back end loads it, divides the three sums
// (one quotient bit a cycle), scans the reference colors (one color a cycle) up to the
// first hit unless the tile is empty, and hands off the result. Tiles that arrive faster
// than the back end finishes them back up in the queue; s_axis_tready drops while full.
// When m_axis_tready is low the result is held in the output register; the back end can
// finish one more tile behind it and the front keeps accepting until the queue fills.
// Reset clears sums, count, queue and output, and sets the thresholds to 1400 (dark, at
// address 0) and 900 (light, at address 4). Write the thresholds only while idle.
module tile_mean_color_classifier #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel[23:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // tile_class[2:0], overflowed[3], zero[7:4]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tmcc_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW  = $clog2(MAX_SAMPLES * 255 + 1);
  localparam int unsigned TileW = 3 * SumW + CntW + 1;

  logic [ThrW-1:0]  dark_thr_q, light_thr_q;
  logic             cfg_wr;
  cfg_reg_e         cfg_sel;
  logic             tile_push, q_full, q_empty, q_pop;
  logic [TileW-1:0] tile_in, tile_out;
  class_e           res_class;
  logic             res_ovf;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_thr_q  <= DarkThrReset;
      light_thr_q <= LightThrReset;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_DARK_THR:  dark_thr_q  <= pwdata[ThrW-1:0];
        REG_LIGHT_THR: light_thr_q <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_DARK_THR:  prdata = 32'(dark_thr_q);
      REG_LIGHT_THR: prdata = 32'(light_thr_q);
      default:       prdata = '0;
    endcase
  end

  tmcc_front #(.MAX_SAMPLES(MAX_SAMPLES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (s_axis_tvalid),
    .pix_ready_o (s_axis_tready),
    .pixel_i     (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .q_full_i    (q_full),
    .tile_push_o (tile_push),
    .tile_o      (tile_in)
  );

  tmcc_fifo #(.WIDTH(TileW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tile_push),
    .data_i  (tile_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (tile_out),
    .empty_o (q_empty)
  );

  tmcc_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tile_i      (tile_out),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .dark_thr_i  (dark_thr_q),
    .light_thr_i (light_thr_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_class_o (res_class),
    .res_ovf_o   (res_ovf)
  );

  assign m_axis_tdata = {4'b0000, res_ovf, res_class};

endmodule

@@ tb/tile_mean_color_classifier_test.sv @@
// self-checking testbench for the tile mean color classifier: streamed tiles, apb setup, result scoreboard
module tile_mean_color_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tmcc_pkg::*;

  localparam int unsigned TILE_CAP     = 4096;
  localparam int unsigned RANDOM_ITEMS = 1700;

  // dark colors at 0..5, light colors at 6..11, r,g,b from the high byte down
  localparam logic [11:0][23:0] REF_COLORS = {
    {8'd172, 8'd108, 8'd91},  {8'd124, 8'd97,  8'd128}, {8'd124, 8'd183, 8'd98},
    {8'd148, 8'd162, 8'd111}, {8'd116, 8'd190, 8'd219}, {8'd134, 8'd132, 8'd130},
    {8'd144, 8'd50,  8'd24},  {8'd81,  8'd32,  8'd90},  {8'd86,  8'd166, 8'd48},
    {8'd135, 8'd139, 8'd61},  {8'd77,  8'd168, 8'd205}, {8'd89,  8'd87,  8'd85}
  };

  typedef struct packed {
    class_e cls;
    logic   ovf;
  } tile_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // pixel[23:0]
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // tile_class[2:0], overflowed[3], zero[7:4]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tile_result_t    tile_results_q[$];
  logic [ThrW-1:0] dark_limit;
  logic [ThrW-1:0] light_limit;
  logic [19:0]     red_acc;
  logic [19:0]     green_acc;
  logic [19:0]     blue_acc;
  logic [12:0]     sample_cnt;
  logic            dropped_seen;

  bit tx_idle     = 1'b1;
  bit rx_idle     = 1'b1;
  int rx_hold_len = 0;
  int mismatches  = 0;

  tile_mean_color_classifier #(
    .MAX_SAMPLES(TILE_CAP)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result sink: random gap after each beat while rx_idle is set, or a long hold-off on request
  initial begin : result_sink
    int gap;
    gap = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        gap = rx_hold_len;
        rx_hold_len = 0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        gap = rx_idle ? $urandom_range(0, 3) : 0;
      end else if (gap > 0) begin
        gap--;
      end
      m_axis_tready <= rst_ni && (gap == 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    tile_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tile_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: class %0d ovf %0d", m_axis_tdata[2:0],
                   m_axis_tdata[3]);
      end else begin
        want = tile_results_q.pop_front();
        if (m_axis_tdata[2:0] !== want.cls || m_axis_tdata[3] !== want.ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected class %0d ovf %0d, got class %0d ovf %0d",
                     want.cls, want.ovf, m_axis_tdata[2:0], m_axis_tdata[3]);
        end
      end
    end
  end

  task automatic send_sample(input logic [23:0] px, input logic last);
    int              gap;
    int              dr, dg, db;
    bit              hit;
    logic [19:0]     rm, gm, bm;
    logic [ThrW-1:0] lim;
    tile_result_t    res;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    // beat accepted: update the running tile sums and count
    if (sample_cnt < 13'(TILE_CAP)) begin
      red_acc    += 20'(px[23:16]);
      green_acc  += 20'(px[15:8]);
      blue_acc   += 20'(px[7:0]);
      sample_cnt += 13'd1;
    end else begin
      dropped_seen = 1'b1;
    end
    if (last) begin
      res.cls = CLS_NONE;
      hit = 1'b0;
      if (sample_cnt != 0) begin
        rm = red_acc / 20'(sample_cnt);
        gm = green_acc / 20'(sample_cnt);
        bm = blue_acc / 20'(sample_cnt);
        for (int k = 0; k < 12; k++) begin
          dr = int'(REF_COLORS[k][23:16]) - int'(rm);
          dg = int'(REF_COLORS[k][15:8]) - int'(gm);
          db = int'(REF_COLORS[k][7:0]) - int'(bm);
          lim = (k < 6) ? dark_limit : light_limit;
          if (!hit && (dr * dr + dg * dg + db * db) < int'(lim)) begin
            hit = 1'b1;
            res.cls = class_e'(3'(k % 6 + 1));
          end
        end
      end
      res.ovf = dropped_seen;
      tile_results_q.push_back(res);
      red_acc      = '0;
      green_acc    = '0;
      blue_acc     = '0;
      sample_cnt   = '0;
      dropped_seen = 1'b0;
    end
  endtask

  // amp < 0 gives fully random pixels, else each channel is base +/- amp, clamped
  task automatic send_tile(input logic [23:0] base, input int amp, input int len,
                           input bit close);
    logic [23:0] px;
    int          v;
    for (int i = 0; i < len; i++) begin
      if (amp < 0) begin
        px = 24'($urandom);
      end else begin
        for (int c = 0; c < 3; c++) begin
          v = int'(base[8*c +: 8]) + int'($urandom_range(0, 2 * amp)) - amp;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          px[8*c +: 8] = 8'(v);
        end
      end
      send_sample(px, close && (i == len - 1));
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tile_results_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic apb_access(input cfg_reg_e idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [ThrW-1:0] dark, input logic [ThrW-1:0] light);
    logic [31:0]     rd;
    logic [ThrW-1:0] want;
    drain_results();
    apb_access(REG_DARK_THR, 1'b1, 32'(dark), rd);
    apb_access(REG_LIGHT_THR, 1'b1, 32'(light), rd);
    dark_limit  = dark;
    light_limit = light;
    for (int i = 0; i < 2; i++) begin
      apb_access(cfg_reg_e'(1'(i)), 1'b0, '0, rd);
      want = (i == 0) ? dark : light;
      if (rd[ThrW-1:0] !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("threshold readback at %0d: expected %0d, got %0d", 4 * i, want,
                   rd[ThrW-1:0]);
      end
    end
  endtask

  task automatic test_reference_colors();
    // reset thresholds, one-sample tiles on every reference color and the corners
    for (int k = 0; k < 12; k++) send_sample(REF_COLORS[k], 1'b1);
    send_sample(24'h000000, 1'b1);
    send_sample(24'hFFFFFF, 1'b1);
    // truncating mean
    send_sample(24'h5A5856, 1'b0);
    send_sample(24'h595756, 1'b0);
    send_sample(24'h585655, 1'b1);
  endtask

  task automatic test_threshold_edges();
    // distance exactly at the limit is no hit, one above is
    set_thresholds(18'd100, 18'd0);
    send_sample({8'd79, 8'd87, 8'd85}, 1'b1);
    set_thresholds(18'd101, 18'd0);
    send_sample({8'd79, 8'd87, 8'd85}, 1'b1);
    set_thresholds(18'd0, 18'd0);
    send_sample(REF_COLORS[0], 1'b1);
    send_sample(REF_COLORS[6], 1'b1);
    set_thresholds(18'd1, 18'd1);
    send_sample(REF_COLORS[9], 1'b1);
    send_sample(REF_COLORS[4], 1'b1);
    set_thresholds(18'h3FFFF, 18'h3FFFF);
    send_sample(24'h000000, 1'b1);
    send_sample(24'hFFFFFF, 1'b1);
    set_thresholds(18'd0, 18'h3FFFF);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'h000000, 1'b1);
  endtask

  task automatic test_tile_overflow();
    set_thresholds(DarkThrReset, LightThrReset);
    send_tile(REF_COLORS[2], 6, TILE_CAP, 1'b1);
    // two samples past the cap, the dropped last one still closes the tile
    send_tile(REF_COLORS[5], 6, TILE_CAP, 1'b0);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
    send_tile(REF_COLORS[1], 6, TILE_CAP, 1'b0);
    send_sample(24'hFFFFFF, 1'b1);
    send_tile(REF_COLORS[7], 0, 2, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_hold_len = 400;
    for (int i = 0; i < 40; i++) send_tile(REF_COLORS[$urandom_range(0, 11)], 4, 1, 1'b1);
    drain_results();
    for (int i = 0; i < 20; i++)
      send_tile(REF_COLORS[$urandom_range(0, 11)], 4, $urandom_range(1, 3), 1'b1);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_tiles();
    int sent;
    int len;
    int kind;
    int amp;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_thresholds(DarkThrReset, LightThrReset);
        4: set_thresholds(ThrW'($urandom_range(0, 262143)), ThrW'($urandom_range(0, 262143)));
        5: set_thresholds(ThrW'($urandom_range(0, 3000)), 18'h3FFFF);
        default: set_thresholds(ThrW'($urandom_range(0, 6000)), ThrW'($urandom_range(0, 6000)));
      endcase
      tx_idle = (phase != 1) && (phase != 3);
      rx_idle = (phase != 1) && (phase != 2);
      sent = 0;
      while (sent < RANDOM_ITEMS / 6) begin
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
          0: amp = 0;
          1: amp = 3;
          2: amp = 12;
          default: amp = 40;
        endcase
        if (kind < 75)
          send_tile(REF_COLORS[$urandom_range(0, 11)], amp, len, 1'b1);
        else if (kind < 95)
          send_tile('0, -1, len, 1'b1);
        else
          send_tile($urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000, 0, len, 1'b1);
        sent += len;
        if ($urandom_range(0, 29) == 0) drain_results();
      end
      drain_results();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    dark_limit   = DarkThrReset;
    light_limit  = LightThrReset;
    red_acc      = '0;
    green_acc    = '0;
    blue_acc     = '0;
    sample_cnt   = '0;
    dropped_seen = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reference_colors();
    test_threshold_edges();
    test_tile_overflow();
    test_backpressure();
    test_random_tiles();
    drain_results();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
